// File: hdl/load_store_data_memory_top_assert.svh
// Assertion macros for the load/store data memory checker.
// Expects signals named clk and rst_n in the scope where the macros are used.
`ifndef LOAD_STORE_DATA_MEMORY_TOP_ASSERT_SVH
`define LOAD_STORE_DATA_MEMORY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LSDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define LSDM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lsdm_pkg.sv
// Shared constants for the load/store data memory.
// No dependencies; used by the interfaces, the top level and the checker.
package lsdm_pkg;

  // Field widths fixed by the port format
  localparam int ADDR_W         = 14;
  localparam int DATA_W         = 32;
  localparam int SIZE_W         = 2;
  localparam int LANES          = DATA_W / 8;
  localparam int WIDX_W         = ADDR_W - 2;
  localparam int ADDR_WORDS     = 1 << WIDX_W;
  localparam int DEPTH_WORDS_DEF = 4096;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  // Access size codes
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_RSVD = 2'd3;

endpackage

// File: hdl/lsdm_req_if.sv
// Request channel of the load/store data memory (valid/ready handshake).
// Depends on lsdm_pkg for field widths.
interface lsdm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [lsdm_pkg::SIZE_W-1:0]   access_size;
  logic                          zero_extend;
  logic [lsdm_pkg::ADDR_W-1:0]   byte_address;
  logic [lsdm_pkg::DATA_W-1:0]   store_data;

  modport source (output valid, cmd, access_size, zero_extend, byte_address, store_data,
                  input ready);
  modport sink   (input valid, cmd, access_size, zero_extend, byte_address, store_data,
                  output ready);
endinterface

// File: hdl/lsdm_rsp_if.sv
// Response channel of the load/store data memory (valid/ready handshake).
// Depends on lsdm_pkg for field widths.
interface lsdm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [lsdm_pkg::DATA_W-1:0] load_data;
  logic                               misaligned;

  modport source (output valid, load_data, misaligned, input ready);
  modport sink   (input valid, load_data, misaligned, output ready);
endinterface

// File: hdl/load_store_data_memory_top.sv
// Load/store data memory: byte-addressed store of DEPTH_WORDS 32-bit words,
// built on lsdm_ram and lsdm_pkg, with lsdm_req_if / lsdm_rsp_if channels.
// in_req carries one load or store of a byte, halfword or word per transaction;
// out_rsp returns exactly one response per request, in order: the sign- or
// zero-extended load value (zero for stores, misaligned or reserved-size accesses) and a misaligned flag.
// Misaligned accesses and the unused size code leave the memory untouched.
// Word index is the byte address divided by four, wrapped modulo DEPTH_WORDS.
// A response passes through the registered RAM read and then the output register.
// Throughput: one transaction per cycle while out_rsp does not stall; the single
// RAM port serves the store write and the read of the accepted request in that cycle.
// When out_rsp stalls, the request in flight waits in the read stage with the
// RAM read data held, and in_req.ready drops until the output drains.
// Reset (rst_n low, synchronous) empties the pipeline; memory contents are
// not cleared and a location reads as undefined until written.
module load_store_data_memory_top #(
  parameter int DEPTH_WORDS = lsdm_pkg::DEPTH_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lsdm_req_if.sink      in_req,
  lsdm_rsp_if.source    out_rsp
);

  localparam int AW     = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
  localparam int WIDX_W = lsdm_pkg::WIDX_W;
  localparam int DATA_W = lsdm_pkg::DATA_W;
  localparam int LANES  = lsdm_pkg::LANES;
  // Conditional subtract steps needed to wrap the word index into the memory
  localparam int QBITS  = (DEPTH_WORDS >= lsdm_pkg::ADDR_WORDS) ? 0 :
    $clog2((lsdm_pkg::ADDR_WORDS + DEPTH_WORDS - 1) / DEPTH_WORDS);

  typedef struct packed {
    logic                        load_ok;
    logic [lsdm_pkg::SIZE_W-1:0] size;
    logic                        zext;
    logic [1:0]                  off;
    logic                        misal;
  } lsdm_meta_t;

  logic                        in_acc;
  logic                        s1_adv;
  logic                        misal;
  logic                        op_ok;
  logic [1:0]                  off;
  logic [WIDX_W-1:0]           word_rem;
  logic [AW-1:0]               ram_addr;
  logic                        ram_we;
  logic [LANES-1:0]            ram_be;
  logic [DATA_W-1:0]           ram_wdata;
  logic [DATA_W-1:0]           ram_rdata;
  logic [DATA_W-1:0]           shifted;
  logic [DATA_W-1:0]           fmt_data;

  logic                        s1_valid_r, s1_valid_nxt;
  lsdm_meta_t                  s1_meta_r, s1_meta_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]    out_load_data_r, out_load_data_nxt;
  logic                        out_misaligned_r, out_misaligned_nxt;

  // Handshake: read stage moves on when the output register is free
  assign s1_adv       = !out_valid_r || out_rsp.ready;
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_acc       = in_req.valid && in_req.ready;

  // Alignment check and request decode
  assign off = in_req.byte_address[1:0];
  always_comb begin
    unique case (in_req.access_size)
      lsdm_pkg::SIZE_HALF: misal = off[0];
      lsdm_pkg::SIZE_WORD: misal = (off != 2'b00);
      default:             misal = 1'b0;
    endcase
  end
  assign op_ok = (in_req.access_size != lsdm_pkg::SIZE_RSVD) && !misal;

  // Word index wrapped modulo the memory depth
  always_comb begin
    word_rem = in_req.byte_address[lsdm_pkg::ADDR_W-1:2];
    for (int k = QBITS - 1; k >= 0; k--) begin
      if (32'(word_rem) >= (32'(DEPTH_WORDS) << k)) begin
        word_rem = word_rem - WIDX_W'(32'(DEPTH_WORDS) << k);
      end
    end
  end
  assign ram_addr = AW'(word_rem);

  // Store lanes and lane-aligned write data
  always_comb begin
    unique case (in_req.access_size)
      lsdm_pkg::SIZE_BYTE: ram_be = LANES'(4'b0001) << off;
      lsdm_pkg::SIZE_HALF: ram_be = LANES'(4'b0011) << off;
      lsdm_pkg::SIZE_WORD: ram_be = {LANES{1'b1}};
      default:             ram_be = '0;
    endcase
  end
  assign ram_wdata = in_req.store_data << {off, 3'b000};
  assign ram_we    = in_acc && (in_req.cmd == lsdm_pkg::CMD_STORE) && op_ok;

  lsdm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .be    (ram_be),
    .re    (in_acc),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Read stage next state
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_meta_nxt  = s1_meta_r;
    if (in_acc) begin
      s1_valid_nxt        = 1'b1;
      s1_meta_nxt.load_ok = op_ok && (in_req.cmd == lsdm_pkg::CMD_LOAD);
      s1_meta_nxt.size    = in_req.access_size;
      s1_meta_nxt.zext    = in_req.zero_extend;
      s1_meta_nxt.off     = off;
      s1_meta_nxt.misal   = misal;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Lane extraction and extension of the load value
  assign shifted = ram_rdata >> {s1_meta_r.off, 3'b000};
  always_comb begin
    unique case (s1_meta_r.size)
      lsdm_pkg::SIZE_BYTE:
        fmt_data = s1_meta_r.zext ? {24'b0, shifted[7:0]} : {{24{shifted[7]}}, shifted[7:0]};
      lsdm_pkg::SIZE_HALF:
        fmt_data = s1_meta_r.zext ? {16'b0, shifted[15:0]}
                                  : {{16{shifted[15]}}, shifted[15:0]};
      lsdm_pkg::SIZE_WORD: fmt_data = shifted;
      default:             fmt_data = '0;
    endcase
  end

  // Output register next state
  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_load_data_nxt  = out_load_data_r;
    out_misaligned_nxt = out_misaligned_r;
    if (s1_adv) begin
      out_valid_nxt      = s1_valid_r;
      out_load_data_nxt  = s1_meta_r.load_ok ? signed'(fmt_data) : '0;
      out_misaligned_nxt = s1_meta_r.misal;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_meta_r        <= s1_meta_nxt;
    out_load_data_r  <= out_load_data_nxt;
    out_misaligned_r <= out_misaligned_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.load_data  = out_load_data_r;
  assign out_rsp.misaligned = out_misaligned_r;

endmodule

// File: hdl/lsdm_ram.sv
// Generic single-port synchronous RAM with byte-lane write enables.
// Read data is registered and holds while no read is issued. No dependencies.
module lsdm_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 4096,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NB    = WIDTH / 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [NB-1:0]    be,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Byte-lane write
  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < NB; b++) begin
        if (be[b]) begin
          mem[addr][b*8 +: 8] <= wdata[b*8 +: 8];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lsdm_checker.sv
// Port-level checker for load_store_data_memory_top, bound to every instance.
// Depends on lsdm_pkg and load_store_data_memory_top_assert.svh.
`include "load_store_data_memory_top_assert.svh"

module lsdm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lsdm_pkg::DATA_W-1:0] out_load_data,
  input logic                               out_misaligned
);

  logic in_acc;
  logic misal_rsp;

  // Request handshake and misaligned response offered
  assign in_acc    = in_valid && in_ready;
  assign misal_rsp = out_valid && out_misaligned;

  // Stalled response stays offered
  `LSDM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "response dropped in stall")

  // A newly offered response traces back to a transaction taken, through the read stage and output register
  `LSDM_ASSERT_IMP(a_rise_latency, $rose(out_valid), $past(in_acc, 2), "response without request")

  // An empty output never blocks the request side
  `LSDM_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "request blocked with output empty")

  // Misaligned accesses return no data
  `LSDM_ASSERT_IMP(a_misal_zero, misal_rsp, out_load_data == '0, "misaligned response with data")

endmodule

bind load_store_data_memory_top lsdm_checker u_lsdm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_load_data  (out_rsp.load_data),
  .out_misaligned (out_rsp.misaligned)
);
